### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/bprf_pkg.sv
// ---------------------------------------------------------------------------
// bprf_pkg
// Types and constants of the bus packet receive filter.
// ---------------------------------------------------------------------------
package bprf_pkg;

    // Header layout
    localparam int         HDR_DEPTH  = 7;
    localparam logic [2:0] HDR_BYTES  = 3'(HDR_DEPTH);
    localparam logic [2:0] POS_DEST   = 3'd0;
    localparam logic [2:0] POS_LEN    = 3'd1;
    localparam logic [2:0] POS_SRC    = 3'd2;
    localparam logic [2:0] POS_STATUS = 3'd3;
    localparam logic [2:0] POS_ID     = 3'd4;
    localparam logic [2:0] POS_SUM    = 3'd5;
    localparam logic [2:0] POS_CMD    = 3'd6;

    // Bytes left after the address check: header rest plus payload
    localparam logic [8:0] SKIP_HDR_REST = 9'(HDR_DEPTH - 2);

    localparam logic [7:0] STATUS_CHECK = 8'h00;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;

    // Register indexes
    localparam logic REG_OWN_ADDRESS       = 1'b0;
    localparam logic REG_BROADCAST_ADDRESS = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] frame_destination;
        logic [7:0] frame_source;
        logic [7:0] frame_status;
        logic [7:0] frame_id;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
        logic [7:0] payload_byte;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] own_address;
        logic [7:0] broadcast_address;
    } cfg_t;

endpackage

### rtl/bprf_framer.sv
// ---------------------------------------------------------------------------
// bprf_framer
// Frame state, header store and per-byte decision of the receive filter.
// ---------------------------------------------------------------------------
module bprf_framer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  bprf_pkg::in_beat_t  beat,
    input  bprf_pkg::cfg_t      cfg,
    output logic                res_valid,
    output bprf_pkg::out_beat_t res
);

    logic [7:0] hdr_reg [bprf_pkg::HDR_DEPTH];
    logic [2:0] hcount_reg, hcount_next;
    logic [7:0] pcount_reg, pcount_next;
    logic [8:0] skip_reg, skip_next;
    logic       deliv_reg, deliv_next;

    logic       hdr_wr;
    logic [7:0] b;
    logic [7:0] sum_x;
    logic [7:0] frame_len;
    logic [7:0] pcount_inc;
    logic       done;

    assign b          = beat.rx_byte;
    assign frame_len  = hdr_reg[bprf_pkg::POS_LEN];
    assign pcount_inc = pcount_reg + 8'd1;
    assign done       = (pcount_inc == frame_len);
    assign hdr_wr     = step && !beat.line_error && (skip_reg == 9'd0)
                        && (hcount_reg < bprf_pkg::HDR_BYTES);

    // XOR of the six non-checksum bytes; command is the byte arriving now
    assign sum_x = hdr_reg[bprf_pkg::POS_DEST] ^ hdr_reg[bprf_pkg::POS_LEN]
                 ^ hdr_reg[bprf_pkg::POS_SRC] ^ hdr_reg[bprf_pkg::POS_STATUS]
                 ^ hdr_reg[bprf_pkg::POS_ID] ^ b;

    // Next state and result
    always_comb
    begin
        hcount_next = hcount_reg;
        pcount_next = pcount_reg;
        skip_next   = skip_reg;
        deliv_next  = deliv_reg;
        res_valid   = 1'b0;

        res.item_kind         = bprf_pkg::KIND_HEADER;
        res.frame_destination = hdr_reg[bprf_pkg::POS_DEST];
        res.frame_source      = hdr_reg[bprf_pkg::POS_SRC];
        res.frame_status      = hdr_reg[bprf_pkg::POS_STATUS];
        res.frame_id          = hdr_reg[bprf_pkg::POS_ID];
        res.frame_command     = hdr_wr ? b : hdr_reg[bprf_pkg::POS_CMD];
        res.frame_length      = frame_len;
        res.payload_byte      = 8'h00;
        res.last              = 1'b0;

        if (step)
        begin
            priority if (beat.line_error)
            begin
                // abort a frame in delivery, reset the framer
                if (deliv_reg)
                begin
                    res_valid     = 1'b1;
                    res.item_kind = bprf_pkg::KIND_ABORT;
                end
                hcount_next = 3'd0;
                pcount_next = 8'd0;
                skip_next   = 9'd0;
                deliv_next  = 1'b0;
            end
            else if (skip_reg != 9'd0)
            begin
                skip_next = skip_reg - 9'd1;
                if (skip_reg == 9'd1)
                begin
                    hcount_next = 3'd0;
                    pcount_next = 8'd0;
                    deliv_next  = 1'b0;
                end
            end
            else if (hcount_reg < bprf_pkg::HDR_BYTES)
            begin
                hcount_next = hcount_reg + 3'd1;
                if (hcount_reg == bprf_pkg::POS_LEN)
                begin
                    // address filter once destination and length are in
                    if (hdr_reg[bprf_pkg::POS_DEST] != cfg.own_address &&
                        hdr_reg[bprf_pkg::POS_DEST] != cfg.broadcast_address)
                        skip_next = bprf_pkg::SKIP_HDR_REST + {1'b0, b};
                end
                else if (hcount_reg == bprf_pkg::POS_CMD)
                begin
                    priority if (sum_x != hdr_reg[bprf_pkg::POS_SUM])
                    begin
                        if (frame_len == 8'd0)
                            hcount_next = 3'd0;
                        else
                            skip_next = {1'b0, frame_len};
                    end
                    else if (hdr_reg[bprf_pkg::POS_STATUS] == bprf_pkg::STATUS_CHECK)
                    begin
                        // check frame: consumed without a result
                        if (frame_len == 8'd0)
                            hcount_next = 3'd0;
                    end
                    else
                    begin
                        res_valid     = 1'b1;
                        res.item_kind = bprf_pkg::KIND_HEADER;
                        res.last      = (frame_len == 8'd0);
                        if (frame_len == 8'd0)
                            hcount_next = 3'd0;
                        else
                            deliv_next = 1'b1;
                    end
                end
            end
            else
            begin
                // payload phase
                if (pcount_reg >= frame_len)
                begin
                    hcount_next = 3'd0;
                    pcount_next = 8'd0;
                    deliv_next  = 1'b0;
                end
                else
                begin
                    pcount_next = pcount_inc;
                    if (deliv_reg)
                    begin
                        res_valid        = 1'b1;
                        res.item_kind    = bprf_pkg::KIND_PAYLOAD;
                        res.payload_byte = b;
                        res.last         = done;
                    end
                    if (done)
                    begin
                        hcount_next = 3'd0;
                        pcount_next = 8'd0;
                        deliv_next  = 1'b0;
                    end
                end
            end
        end
    end

    // Header store
    always_ff @(posedge clk)
    begin
        if (hdr_wr)
            hdr_reg[hcount_reg] <= b;
    end

    // Framer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcount_reg <= 3'd0;
            pcount_reg <= 8'd0;
            skip_reg   <= 9'd0;
            deliv_reg  <= 1'b0;
        end
        else
        begin
            hcount_reg <= hcount_next;
            pcount_reg <= pcount_next;
            skip_reg   <= skip_next;
            deliv_reg  <= deliv_next;
        end
    end

endmodule

### rtl/bus_packet_receive_filter_core.sv
// ---------------------------------------------------------------------------
// bus_packet_receive_filter_core
// Bus receive filter: frames bytes, filters by address and checksum,
// delivers header and payload results.
// ---------------------------------------------------------------------------
// Each accepted byte is held in the input register, and its result is
// then held in the result register. Throughput: one byte per cycle
// unless a stalled result blocks; the framer update is one register step.
// Reset: clears framer counters, delivery flag and both valid bits;
// own_address returns to 0 and broadcast_address to 255.
module bus_packet_receive_filter_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bprf_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bprf_pkg::out_beat_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data
);

    bprf_pkg::cfg_t      cfg_reg;
    logic                in_valid_reg;
    bprf_pkg::in_beat_t  in_data_reg;
    logic                out_valid_reg;
    bprf_pkg::out_beat_t out_data_reg;

    logic                proc;
    logic                in_accept;
    logic                res_valid;
    bprf_pkg::out_beat_t res;

    // Held beat is processed when the result slot is free or draining
    assign proc      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address       <= 8'd0;
            cfg_reg.broadcast_address <= 8'd255;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bprf_pkg::REG_OWN_ADDRESS:       cfg_reg.own_address       <= cfg_data;
                bprf_pkg::REG_BROADCAST_ADDRESS: cfg_reg.broadcast_address <= cfg_data;
                default:                         cfg_reg.own_address       <= cfg_data;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (proc)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_data_reg <= in_data;
    end

    bprf_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proc),
        .beat      (in_data_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc)
            out_valid_reg <= res_valid;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc && res_valid)
            out_data_reg <= res;
    end

endmodule

### rtl/bprf_checker.sv
// ---------------------------------------------------------------------------
// bprf_checker
// Port-level assertions for the bus packet receive filter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bprf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input bprf_pkg::out_beat_t out_data
);

    // a stalled result beat holds
    `ASSERT_CLKD(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "result beat changed while stalled")

    // input only backs up behind a blocked result
    `ASSERT_CLKD(a_in_stall_cause, clk, rst_n, in_valid && in_stall |-> out_valid && out_stall, "input stalled with free result slot")

    // payload byte is zero outside payload beats
    `ASSERT_CLKD(a_pay_zero, clk, rst_n, out_valid && out_data.item_kind != bprf_pkg::KIND_PAYLOAD |-> out_data.payload_byte == 8'h00, "payload byte set on non-payload beat")

    // an abort never closes a frame
    `ASSERT_CLKD(a_abort_last, clk, rst_n, out_valid && out_data.item_kind == bprf_pkg::KIND_ABORT |-> !out_data.last, "abort beat flagged last")

endmodule

bind bus_packet_receive_filter_core bprf_checker u_bprf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
